// ===== rtl/pct_pkg.sv =====
`default_nettype none

package pct_pkg;

  // Transform selected by the palette_mode register.
  typedef enum logic [1:0] {
    MODE_PASS    = 2'd0,
    MODE_SHUFFLE = 2'd1,
    MODE_GRAY    = 2'd2,
    MODE_NEG     = 2'd3
  } mode_t;

  // Channel orders, written as the new (red, green, blue).
  localparam logic [2:0] PERM_RGB = 3'd0;
  localparam logic [2:0] PERM_RBG = 3'd1;
  localparam logic [2:0] PERM_GRB = 3'd2;
  localparam logic [2:0] PERM_GBR = 3'd3;
  localparam logic [2:0] PERM_BRG = 3'd4;
  localparam logic [2:0] PERM_BGR = 3'd5;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_MODE  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_TABLE = 1'd1;

  localparam int unsigned CH_W    = 5;
  localparam int unsigned COLOR_W = 16;
  localparam int unsigned INDEX_W = 8;
  localparam int unsigned TABLE_W = 48;
  localparam int unsigned CFG_W   = 48;

  // Luma weights.
  localparam logic [11:0] W_RED   = 12'd77;
  localparam logic [12:0] W_GREEN = 13'd150;
  localparam logic [9:0]  W_BLUE  = 10'd29;

  // Word held after the first stage: split channels and the group's code.
  typedef struct packed {
    logic            keep;
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
    mode_t           mode;
    logic [2:0]      code;
  } s1_t;

  // Word held after the second stage: weighted channels and the other results.
  typedef struct packed {
    logic        keep;
    mode_t       mode;
    logic [11:0] prod_r;
    logic [12:0] prod_g;
    logic [9:0]  prod_b;
    logic [14:0] alt;
  } s2_t;

endpackage

`default_nettype wire

// ===== rtl/pct_front.sv =====
`default_nettype none

module pct_front (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [pct_pkg::COLOR_W-1:0]   color,
  input  wire logic [pct_pkg::INDEX_W-1:0]   index,
  input  wire pct_pkg::mode_t                mode,
  input  wire logic [pct_pkg::TABLE_W-1:0]   perm_table,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output pct_pkg::s1_t                       out_data
);

  logic         valid_r;
  pct_pkg::s1_t data_r;
  pct_pkg::s1_t data_nxt;
  logic [3:0]   grp;
  logic [5:0]   shift;

  assign grp   = index[7:4];
  // Three bits per group: offset is 3 * group.
  assign shift = {2'b00, grp} + {1'b0, grp, 1'b0};

  always_comb begin
    data_nxt.keep  = color[15];
    data_nxt.red   = color[4:0];
    data_nxt.green = color[9:5];
    data_nxt.blue  = color[14:10];
    data_nxt.mode  = mode;
    data_nxt.code  = perm_table[shift +: 3];
  end

  assign in_ready  = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_data  = data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      data_r <= data_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/pct_mix.sv =====
`default_nettype none

module pct_mix (
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire logic   in_valid,
  output logic        in_ready,
  input  wire pct_pkg::s1_t in_data,
  output logic        out_valid,
  input  wire logic   out_ready,
  output pct_pkg::s2_t out_data
);

  logic                      valid_r;
  pct_pkg::s2_t              data_r;
  pct_pkg::s2_t              data_nxt;
  logic [pct_pkg::CH_W-1:0]  nr;
  logic [pct_pkg::CH_W-1:0]  ng;
  logic [pct_pkg::CH_W-1:0]  nb;

  always_comb begin
    nr = in_data.red;
    ng = in_data.green;
    nb = in_data.blue;
    case (in_data.code)
      pct_pkg::PERM_RBG: begin
        ng = in_data.blue;
        nb = in_data.green;
      end
      pct_pkg::PERM_GRB: begin
        nr = in_data.green;
        ng = in_data.red;
      end
      pct_pkg::PERM_GBR: begin
        nr = in_data.green;
        ng = in_data.blue;
        nb = in_data.red;
      end
      pct_pkg::PERM_BRG: begin
        nr = in_data.blue;
        ng = in_data.red;
        nb = in_data.green;
      end
      pct_pkg::PERM_BGR: begin
        nr = in_data.blue;
        nb = in_data.red;
      end
      default: begin
        // The unused codes leave the order as it is.
        nr = in_data.red;
      end
    endcase
  end

  always_comb begin
    data_nxt.keep   = in_data.keep;
    data_nxt.mode   = in_data.mode;
    data_nxt.prod_r = {7'd0, in_data.red} * pct_pkg::W_RED;
    data_nxt.prod_g = {8'd0, in_data.green} * pct_pkg::W_GREEN;
    data_nxt.prod_b = {5'd0, in_data.blue} * pct_pkg::W_BLUE;
    case (in_data.mode)
      pct_pkg::MODE_SHUFFLE: data_nxt.alt = {nb, ng, nr};
      pct_pkg::MODE_NEG:     data_nxt.alt = ~{in_data.blue, in_data.green, in_data.red};
      default:               data_nxt.alt = {in_data.blue, in_data.green, in_data.red};
    endcase
  end

  assign in_ready  = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_data  = data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      data_r <= data_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/pct_back.sv =====
`default_nettype none

module pct_back (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire pct_pkg::s2_t                in_data,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic [pct_pkg::COLOR_W-1:0]      out_data
);

  logic                         valid_r;
  logic [pct_pkg::COLOR_W-1:0]  data_r;
  logic [pct_pkg::COLOR_W-1:0]  data_nxt;
  logic [12:0]                  sum;
  logic [pct_pkg::CH_W-1:0]     luma;

  // The weighted sum stays below 8192, so bits 12..8 are the whole luma.
  assign sum  = {1'b0, in_data.prod_r} + in_data.prod_g + {3'd0, in_data.prod_b};
  assign luma = sum[12:8];

  always_comb begin
    case (in_data.mode)
      pct_pkg::MODE_GRAY: data_nxt = {in_data.keep, luma, luma, luma};
      default:            data_nxt = {in_data.keep, in_data.alt};
    endcase
  end

  assign in_ready  = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_data  = data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      data_r <= data_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/palette_color_transform_unit.sv =====
// Palette colour transform: BGR555 pass-through, channel shuffle, grayscale
// or negative, chosen by the palette_mode register.
// The in_ stream carries one colour word with its palette index; the out_
// stream returns one transformed colour word for each input word, in order.
// The cfg_ channel writes palette_mode (index 0) or group_perm_table
// (index 1); it is always ready and is meant to be used while the block is
// idle. In shuffle mode bits 7..4 of the palette index pick a 3-bit order
// code from the table.
// There are three register stages: field split and code lookup, luma
// products and shuffle, then the luma sum and final selection into the
// output register.
// Throughput is one word per clock. Each stage has its own valid bit and
// advances when it is empty or the next stage takes its word, so a stalled
// receiver fills the pipeline and in_tready falls only once all three
// stages hold a word; nothing is lost or repeated.
// Synchronous reset empties the pipeline and clears both registers to zero.
`default_nettype none

module palette_color_transform_unit (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_tvalid,
  output logic                                 in_tready,
  // color_in [15:0], palette_index [23:16]
  input  wire logic [23:0]                     in_tdata,
  output logic                                 out_tvalid,
  input  wire logic                            out_tready,
  // color_out [15:0]
  output logic [15:0]                          out_tdata,
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [pct_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [pct_pkg::CFG_W-1:0]       cfg_data
);

  pct_pkg::mode_t                 mode_r;
  logic [pct_pkg::TABLE_W-1:0]    table_r;

  logic         s1_valid;
  logic         s1_ready;
  pct_pkg::s1_t s1_data;
  logic         s2_valid;
  logic         s2_ready;
  pct_pkg::s2_t s2_data;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= pct_pkg::MODE_PASS;
      table_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        pct_pkg::CFG_IDX_MODE:  mode_r  <= pct_pkg::mode_t'(cfg_data[1:0]);
        pct_pkg::CFG_IDX_TABLE: table_r <= cfg_data[pct_pkg::TABLE_W-1:0];
        default: begin
          table_r <= table_r;
        end
      endcase
    end
  end

  pct_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .color      (in_tdata[15:0]),
    .index      (in_tdata[23:16]),
    .mode       (mode_r),
    .perm_table (table_r),
    .out_valid  (s1_valid),
    .out_ready  (s1_ready),
    .out_data   (s1_data)
  );

  pct_mix u_mix (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (s1_valid),
    .in_ready  (s1_ready),
    .in_data   (s1_data),
    .out_valid (s2_valid),
    .out_ready (s2_ready),
    .out_data  (s2_data)
  );

  pct_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (s2_valid),
    .in_ready  (s2_ready),
    .in_data   (s2_data),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_data  (out_tdata)
  );

  // An empty pipeline always takes a word.
  a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
    (!s1_valid && !s2_valid && !out_tvalid) |-> in_tready)
    else $error("in_tready low with an empty pipeline");

  // Back-pressure reaches the input only once every stage is full.
  a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (s1_valid && s2_valid && out_tvalid))
    else $error("in_tready low while a stage is empty");

  // With the receiver ready, a pass-through word appears unchanged at the output.
  a_pass_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && mode_r == pct_pkg::MODE_PASS)
      ##1 out_tready ##1 out_tready
      |=> (out_tvalid && out_tdata == $past(in_tdata[15:0], 3)))
    else $error("pass-through word lost or altered");

endmodule

`default_nettype wire
